FILE: src/expression_token_lexer_assert.svh
// Assertion macros for the checker file of the token lexer.
`ifndef EXPRESSION_TOKEN_LEXER_ASSERT_SVH
`define EXPRESSION_TOKEN_LEXER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ETL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ETL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/etl_pkg.sv
// ----------------------------------------------------------------------------
// etl_pkg
// Types, character codes and lookup functions shared by the token lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package etl_pkg;

   localparam int MAX_LEN  = 1024;
   localparam int POS_BITS = $clog2(MAX_LEN + 1);
   // Position counter is at least as wide as the token length field.
   localparam int POS_W    = (POS_BITS > 11) ? POS_BITS : 11;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_POINT  = 8'h2E;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_BANG   = 8'h21;

   typedef enum logic [2:0] {
      KIND_NUMBER, KIND_VARIABLE, KIND_FUNCTION, KIND_OPERATOR,
      KIND_LPAREN, KIND_RPAREN, KIND_ERROR, KIND_END
   } kind_type;

   typedef enum logic [2:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_POW, OP_FACT, OP_IDIV
   } op_type;

   typedef enum logic [1:0] {
      ERR_NONE, ERR_POINT, ERR_CHAR, ERR_LONG
   } err_type;

   typedef struct packed {
      kind_type    kind;
      op_type      op;
      logic [2:0]  prec;
      logic        ra;
      logic [9:0]  start;
      logic [10:0] len;
      err_type     err;
   } token_type;

   // Results of one accepted character: up to two tokens, in order.
   typedef struct packed {
      logic [1:0]      cnt;
      token_type [1:0] tok;
   } bundle_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'd48 && c <= 8'd57;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
   endfunction

   function automatic logic [2:0] op_prec(input op_type op);
      case (op)
         OP_ADD, OP_SUB:                  return 3'd1;
         OP_MUL, OP_DIV, OP_MOD, OP_IDIV: return 3'd2;
         OP_POW:                          return 3'd3;
         OP_FACT:                         return 3'd4;
         default:                         return 3'd0;
      endcase
   endfunction

   function automatic token_type make_tok(input kind_type kind, input op_type op,
                                          input logic [9:0] start,
                                          input logic [10:0] len, input err_type err);
      token_type t;
      t.kind  = kind;
      t.op    = (kind == KIND_OPERATOR) ? op : OP_ADD;
      t.prec  = (kind == KIND_OPERATOR) ? op_prec(op) : 3'd0;
      t.ra    = (kind == KIND_OPERATOR) && (op == OP_POW || op == OP_FACT);
      t.start = start;
      t.len   = len;
      t.err   = err;
      return t;
   endfunction

endpackage

`default_nettype wire

FILE: src/etl_front.sv
// ----------------------------------------------------------------------------
// etl_front
// Character classifier and lexer state; turns each character into 0-2 tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module etl_front import etl_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_ch,
   input  wire logic       req_end_of_expr,
   input  wire logic       q_full,
   output logic            q_push,
   output bundle_type      q_data
);

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_NUM, MODE_ID, MODE_IDW, MODE_SLASH, MODE_ERR
   } mode_type;

   mode_type          mode_ff, mode_in;
   logic              seen_ff, seen_in;
   logic [9:0]        start_ff, start_in;
   logic [10:0]       len_ff, len_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              unary_ff, unary_in;

   logic              fire;
   logic              do_flush, do_idle;
   logic [1:0]        k;
   bundle_type        bnd;
   logic [9:0]        p10;

   assign req_ready = !q_full;
   assign fire      = req_valid && req_ready;
   assign p10       = pos_ff[9:0];

   always_comb begin
      mode_in  = mode_ff;
      seen_in  = seen_ff;
      start_in = start_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      unary_in = unary_ff;
      do_flush = 1'b0;
      do_idle  = 1'b0;
      k        = 2'd0;
      bnd      = '0;

      if (fire) begin
         if (req_end_of_expr) begin
            do_flush = (mode_ff != MODE_ERR);
         end else if (mode_ff == MODE_ERR) begin
            // locked: drop the character
         end else if (pos_ff >= POS_W'(MAX_LEN)) begin
            mode_in = MODE_ERR;
            bnd.tok[k[0]] = make_tok(KIND_ERROR, OP_ADD, p10, 11'd0, ERR_LONG);
            k = k + 2'd1;
         end else begin
            pos_in = pos_ff + POS_W'(1);
            case (mode_ff)
               MODE_NUM: begin
                  if (is_digit(req_ch)) begin
                     len_in = len_ff + 11'd1;
                  end else if (req_ch == CH_POINT) begin
                     if (seen_ff) begin
                        mode_in = MODE_ERR;
                        bnd.tok[k[0]] = make_tok(KIND_ERROR, OP_ADD, p10, 11'd1, ERR_POINT);
                        k = k + 2'd1;
                     end else begin
                        seen_in = 1'b1;
                        len_in  = len_ff + 11'd1;
                     end
                  end else begin
                     do_flush = 1'b1;
                     do_idle  = 1'b1;
                  end
               end
               MODE_ID, MODE_IDW: begin
                  if (mode_ff == MODE_ID && is_letter(req_ch)) begin
                     len_in = len_ff + 11'd1;
                  end else if (is_blank(req_ch)) begin
                     mode_in = MODE_IDW;
                  end else if (req_ch == CH_LPAREN) begin
                     bnd.tok[k[0]] = make_tok(KIND_FUNCTION, OP_ADD, start_ff, len_ff,
                                              ERR_NONE);
                     k = k + 2'd1;
                     bnd.tok[k[0]] = make_tok(KIND_LPAREN, OP_ADD, p10, 11'd1, ERR_NONE);
                     k = k + 2'd1;
                     mode_in  = MODE_IDLE;
                     unary_in = 1'b1;
                  end else begin
                     do_flush = 1'b1;
                     do_idle  = 1'b1;
                  end
               end
               MODE_SLASH: begin
                  if (req_ch == CH_SLASH) begin
                     bnd.tok[k[0]] = make_tok(KIND_OPERATOR, OP_IDIV, start_ff, 11'd2,
                                              ERR_NONE);
                     k = k + 2'd1;
                     mode_in  = MODE_IDLE;
                     unary_in = 1'b1;
                  end else begin
                     do_flush = 1'b1;
                     do_idle  = 1'b1;
                  end
               end
               default: begin
                  do_idle = 1'b1;
               end
            endcase
         end
      end

      // Emit the pending token before whatever the new character starts.
      if (do_flush) begin
         case (mode_ff)
            MODE_NUM: begin
               bnd.tok[k[0]] = make_tok(KIND_NUMBER, OP_ADD, start_ff, len_ff, ERR_NONE);
               k = k + 2'd1;
               unary_in = 1'b0;
            end
            MODE_ID, MODE_IDW: begin
               bnd.tok[k[0]] = make_tok(KIND_VARIABLE, OP_ADD, start_ff, len_ff, ERR_NONE);
               k = k + 2'd1;
               unary_in = 1'b0;
            end
            MODE_SLASH: begin
               bnd.tok[k[0]] = make_tok(KIND_OPERATOR, OP_DIV, start_ff, 11'd1, ERR_NONE);
               k = k + 2'd1;
               unary_in = 1'b1;
            end
            default: begin
            end
         endcase
         mode_in = MODE_IDLE;
      end

      if (do_idle) begin
         mode_in = MODE_IDLE;
         if (is_blank(req_ch)) begin
            // advance the position only
         end else if (is_digit(req_ch) || (req_ch == CH_MINUS && unary_in)) begin
            mode_in  = MODE_NUM;
            start_in = p10;
            len_in   = 11'd1;
            seen_in  = 1'b0;
         end else if (is_letter(req_ch)) begin
            mode_in  = MODE_ID;
            start_in = p10;
            len_in   = 11'd1;
            seen_in  = 1'b0;
         end else if (req_ch == CH_SLASH) begin
            mode_in  = MODE_SLASH;
            start_in = p10;
            len_in   = 11'd1;
            seen_in  = 1'b0;
         end else if (req_ch == CH_LPAREN) begin
            bnd.tok[k[0]] = make_tok(KIND_LPAREN, OP_ADD, p10, 11'd1, ERR_NONE);
            k = k + 2'd1;
            unary_in = 1'b1;
         end else if (req_ch == CH_RPAREN) begin
            bnd.tok[k[0]] = make_tok(KIND_RPAREN, OP_ADD, p10, 11'd1, ERR_NONE);
            k = k + 2'd1;
            unary_in = 1'b0;
         end else if (req_ch == CH_PLUS || req_ch == CH_MINUS || req_ch == CH_STAR ||
                      req_ch == CH_PCT || req_ch == CH_CARET || req_ch == CH_BANG) begin
            case (req_ch)
               CH_PLUS:  bnd.tok[k[0]] = make_tok(KIND_OPERATOR, OP_ADD, p10, 11'd1, ERR_NONE);
               CH_MINUS: bnd.tok[k[0]] = make_tok(KIND_OPERATOR, OP_SUB, p10, 11'd1, ERR_NONE);
               CH_STAR:  bnd.tok[k[0]] = make_tok(KIND_OPERATOR, OP_MUL, p10, 11'd1, ERR_NONE);
               CH_PCT:   bnd.tok[k[0]] = make_tok(KIND_OPERATOR, OP_MOD, p10, 11'd1, ERR_NONE);
               CH_CARET: bnd.tok[k[0]] = make_tok(KIND_OPERATOR, OP_POW, p10, 11'd1, ERR_NONE);
               default:  bnd.tok[k[0]] = make_tok(KIND_OPERATOR, OP_FACT, p10, 11'd1, ERR_NONE);
            endcase
            k = k + 2'd1;
            unary_in = 1'b1;
         end else begin
            mode_in = MODE_ERR;
            bnd.tok[k[0]] = make_tok(KIND_ERROR, OP_ADD, p10, 11'd1, ERR_CHAR);
            k = k + 2'd1;
         end
      end

      if (fire && req_end_of_expr) begin
         bnd.tok[k[0]] = make_tok(KIND_END, OP_ADD, p10, 11'd0, ERR_NONE);
         k = k + 2'd1;
         mode_in  = MODE_IDLE;
         seen_in  = 1'b0;
         start_in = '0;
         len_in   = '0;
         pos_in   = '0;
         unary_in = 1'b1;
      end

      bnd.cnt = k;
   end

   assign q_push = fire && (k != 2'd0);
   assign q_data = bnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         seen_ff  <= 1'b0;
         start_ff <= '0;
         len_ff   <= '0;
         pos_ff   <= '0;
         unary_ff <= 1'b1;
      end else begin
         mode_ff  <= mode_in;
         seen_ff  <= seen_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         unary_ff <= unary_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/etl_fifo.sv
// ----------------------------------------------------------------------------
// etl_fifo
// Short queue of per-character token bundles between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module etl_fifo import etl_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire bundle_type  push_data,
   input  wire logic        pop,
   output logic             full,
   output logic             empty,
   output bundle_type       head
);

   bundle_type             mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]     wr_ff, rd_ff;
   logic [FIFO_AW:0]       count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (FIFO_AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (FIFO_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ff <= wr_ff + FIFO_AW'(1);
         end
         if (do_pop) begin
            rd_ff <= rd_ff + FIFO_AW'(1);
         end
      end
   end

endmodule

`default_nettype wire

FILE: src/etl_back.sv
// ----------------------------------------------------------------------------
// etl_back
// Output stage: takes bundles from the queue and sends one token per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module etl_back import etl_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_empty,
   input  wire bundle_type  q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_token_kind,
   output logic [2:0]       rsp_op_code,
   output logic [2:0]       rsp_precedence,
   output logic             rsp_right_assoc,
   output logic [9:0]       rsp_start_pos,
   output logic [10:0]      rsp_token_len,
   output logic [1:0]       rsp_error_code,
   output logic             rsp_last_in_run
);

   bundle_type  hold_ff;
   logic        valid_ff;
   logic        idx_ff;
   logic        last;
   logic        load;
   token_type   cur;

   assign cur  = hold_ff.tok[idx_ff];
   assign last = (hold_ff.cnt == 2'd1) || idx_ff;
   // Refill when empty or when the final token of the bundle leaves.
   assign load  = (!valid_ff || (rsp_ready && last)) && !q_empty;
   assign q_pop = load;

   always_ff @(posedge clock) begin
      if (load) begin
         hold_ff <= q_head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= 1'b0;
      end else if (valid_ff && rsp_ready) begin
         if (last) begin
            valid_ff <= 1'b0;
            idx_ff   <= 1'b0;
         end else begin
            idx_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_token_kind  = cur.kind;
   assign rsp_op_code     = cur.op;
   assign rsp_precedence  = cur.prec;
   assign rsp_right_assoc = cur.ra;
   assign rsp_start_pos   = cur.start;
   assign rsp_token_len   = cur.len;
   assign rsp_error_code  = cur.err;
   assign rsp_last_in_run = last;

endmodule

`default_nettype wire

FILE: src/expression_token_lexer.sv
// Path: a character's tokens are registered in the bundle queue and then in the
// output hold register. Throughput: one character per cycle while the queue is
// not full; the output side sends one token per cycle while the receiver is ready.
// A four-entry bundle queue absorbs bursts of two-token characters and output stalls.
// Reset clears lexer state, queue pointers and output valid; no clearing pass.
// ----------------------------------------------------------------------------
// expression_token_lexer
// Streaming tokenizer for calculator expressions, one character per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module expression_token_lexer import etl_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_ch,
   input  wire logic        req_end_of_expr,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_token_kind,
   output logic [2:0]       rsp_op_code,
   output logic [2:0]       rsp_precedence,
   output logic             rsp_right_assoc,
   output logic [9:0]       rsp_start_pos,
   output logic [10:0]      rsp_token_len,
   output logic [1:0]       rsp_error_code,
   output logic             rsp_last_in_run
);

   logic        q_full, q_empty, q_push, q_pop;
   bundle_type  q_data, q_head;

   etl_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_ch          (req_ch),
      .req_end_of_expr (req_end_of_expr),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_data          (q_data)
   );

   etl_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   etl_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_op_code     (rsp_op_code),
      .rsp_precedence  (rsp_precedence),
      .rsp_right_assoc (rsp_right_assoc),
      .rsp_start_pos   (rsp_start_pos),
      .rsp_token_len   (rsp_token_len),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_in_run (rsp_last_in_run)
   );

endmodule

`default_nettype wire

FILE: src/etl_checker.sv
// ----------------------------------------------------------------------------
// etl_checker
// Port-level checks on the token stream of the lexer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "expression_token_lexer_assert.svh"

module etl_checker import etl_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_token_kind,
   input wire logic [2:0]  rsp_op_code,
   input wire logic [2:0]  rsp_precedence,
   input wire logic        rsp_right_assoc,
   input wire logic [9:0]  rsp_start_pos,
   input wire logic [10:0] rsp_token_len,
   input wire logic [1:0]  rsp_error_code,
   input wire logic        rsp_last_in_run
);

   logic rsp_stall;

   assign rsp_stall = rsp_valid && !rsp_ready;

   `ETL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
      rsp_valid && $stable(rsp_token_kind) && $stable(rsp_start_pos) &&
      $stable(rsp_token_len) && $stable(rsp_last_in_run) && $stable(rsp_op_code),
      "stalled transaction changed")
   `ETL_ASSERT_NOW(a_end_last, clock, reset, rsp_valid && rsp_token_kind == KIND_END,
      rsp_last_in_run && rsp_token_len == 11'd0, "end marker not final or nonzero length")
   `ETL_ASSERT_NOW(a_nonop_clean, clock, reset,
      rsp_valid && rsp_token_kind != KIND_OPERATOR,
      rsp_op_code == 3'd0 && rsp_precedence == 3'd0 && !rsp_right_assoc,
      "operator fields set on non-operator token")
   `ETL_ASSERT_NOW(a_err_code, clock, reset, rsp_valid,
      (rsp_token_kind == KIND_ERROR) == (rsp_error_code != 2'd0),
      "error code does not match token kind")
   // The queue is empty out of reset, so the input side must be open.
   `ETL_ASSERT_NOW(a_ready_after_reset, clock, reset, $fell(reset), req_ready,
      "input not ready after reset")

endmodule

bind expression_token_lexer etl_checker u_etl_checker (.*);

`default_nettype wire

FILE: tb/tb_expression_token_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_expression_token_lexer
// Self-checking bench for the streaming expression lexer. Characters go in
// through the request channel under random gaps; a cycle-free predictor works
// out the tokens each accepted character must produce, and every token taken
// from the response channel is compared field by field with the oldest one
// still pending. Covers all operators, numbers, variables, functions, errors,
// the lock state and output backpressure.
// ----------------------------------------------------------------------------
module tb_expression_token_lexer;
   import etl_pkg::*;

   localparam int STUCK_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 12;

   typedef logic [7:0] char_q_type[$];

   typedef enum logic [2:0] {
      LX_IDLE, LX_NUMBER, LX_IDENT, LX_IDENT_GAP, LX_SLASH, LX_LOCKED
   } lex_state_type;

   typedef enum logic [1:0] {CC_BLANK, CC_DIGIT, CC_LETTER, CC_OTHER} char_class_type;

   typedef struct {
      kind_type    kind;
      op_type      op;
      logic [2:0]  prec;
      logic        ra;
      logic [9:0]  start;
      logic [10:0] len;
      err_type     err;
      logic        last;
   } token_rec_type;

   localparam logic [7:0] OPERATOR_CHARS [0:6] =
      '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_CARET, CH_BANG};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_ch = 8'd0;
   logic        req_end_of_expr = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_token_kind;
   logic [2:0]  rsp_op_code;
   logic [2:0]  rsp_precedence;
   logic        rsp_right_assoc;
   logic [9:0]  rsp_start_pos;
   logic [10:0] rsp_token_len;
   logic [1:0]  rsp_error_code;
   logic        rsp_last_in_run;

   // lexer state mirrored by the predictor
   lex_state_type lx_state;
   logic        point_seen;
   logic [10:0] tok_start_q;
   logic [10:0] tok_len_q;
   logic [10:0] char_pos;
   logic        unary_ok;

   token_rec_type step_out[$];
   token_rec_type pending_tokens[$];

   int          mismatch_count = 0;
   int          checked_tokens = 0;
   int          sent_chars = 0;
   int          live_chars = 0;
   int          expr_count = 0;
   int          stuck_cycles = 0;
   int          hold_left = 0;
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;
   logic [7:0]  kinds_seen = '0;
   logic [3:0]  errs_seen = '0;

   expression_token_lexer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_ch          (req_ch),
      .req_end_of_expr (req_end_of_expr),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_op_code     (rsp_op_code),
      .rsp_precedence  (rsp_precedence),
      .rsp_right_assoc (rsp_right_assoc),
      .rsp_start_pos   (rsp_start_pos),
      .rsp_token_len   (rsp_token_len),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_in_run (rsp_last_in_run)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic char_class_type classify(input logic [7:0] c);
      if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) return CC_BLANK;
      if (c >= 8'h30 && c <= 8'h39) return CC_DIGIT;
      if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) return CC_LETTER;
      return CC_OTHER;
   endfunction

   function automatic void clear_lexer();
      lx_state    = LX_IDLE;
      point_seen  = 1'b0;
      tok_start_q = '0;
      tok_len_q   = '0;
      char_pos    = '0;
      unary_ok    = 1'b1;
   endfunction

   function automatic void put_token(input kind_type kind, input op_type op,
                                     input logic [2:0] prec, input logic ra,
                                     input logic [10:0] start, input logic [10:0] len,
                                     input err_type err);
      token_rec_type t;
      t.kind  = kind;
      t.op    = op;
      t.prec  = prec;
      t.ra    = ra;
      t.start = start[9:0];
      t.len   = len;
      t.err   = err;
      t.last  = 1'b0;
      step_out.insert(step_out.size(), t);
   endfunction

   function automatic void put_operator(input op_type op, input logic [10:0] start,
                                        input logic [10:0] len);
      logic [2:0] rank;
      case (op)
         OP_ADD, OP_SUB: rank = 3'd1;
         OP_POW:         rank = 3'd3;
         OP_FACT:        rank = 3'd4;
         default:        rank = 3'd2;
      endcase
      unary_ok = 1'b1;
      put_token(KIND_OPERATOR, op, rank, (op == OP_POW) || (op == OP_FACT), start, len,
                ERR_NONE);
   endfunction

   function automatic void flush_pending();
      case (lx_state)
         LX_NUMBER: begin
            put_token(KIND_NUMBER, OP_ADD, 3'd0, 1'b0, tok_start_q, tok_len_q, ERR_NONE);
            unary_ok = 1'b0;
         end
         LX_IDENT, LX_IDENT_GAP: begin
            put_token(KIND_VARIABLE, OP_ADD, 3'd0, 1'b0, tok_start_q, tok_len_q, ERR_NONE);
            unary_ok = 1'b0;
         end
         LX_SLASH: put_operator(OP_DIV, tok_start_q, 11'd1);
         default: ;
      endcase
      lx_state = LX_IDLE;
   endfunction

   function automatic void begin_token(input lex_state_type mode, input logic [10:0] p);
      lx_state    = mode;
      tok_start_q = p;
      tok_len_q   = 11'd1;
      point_seen  = 1'b0;
   endfunction

   // character seen with nothing pending
   function automatic void lex_idle(input logic [7:0] c, input logic [10:0] p);
      char_class_type cls;
      cls = classify(c);
      lx_state = LX_IDLE;
      if (cls == CC_BLANK) return;
      if (cls == CC_DIGIT || (c == CH_MINUS && unary_ok)) begin
         begin_token(LX_NUMBER, p);
         return;
      end
      if (cls == CC_LETTER) begin
         begin_token(LX_IDENT, p);
         return;
      end
      case (c)
         CH_SLASH: begin_token(LX_SLASH, p);
         CH_PLUS:  put_operator(OP_ADD, p, 11'd1);
         CH_MINUS: put_operator(OP_SUB, p, 11'd1);
         CH_STAR:  put_operator(OP_MUL, p, 11'd1);
         CH_PCT:   put_operator(OP_MOD, p, 11'd1);
         CH_CARET: put_operator(OP_POW, p, 11'd1);
         CH_BANG:  put_operator(OP_FACT, p, 11'd1);
         CH_LPAREN: begin
            unary_ok = 1'b1;
            put_token(KIND_LPAREN, OP_ADD, 3'd0, 1'b0, p, 11'd1, ERR_NONE);
         end
         CH_RPAREN: begin
            unary_ok = 1'b0;
            put_token(KIND_RPAREN, OP_ADD, 3'd0, 1'b0, p, 11'd1, ERR_NONE);
         end
         default: begin
            lx_state = LX_LOCKED;
            put_token(KIND_ERROR, OP_ADD, 3'd0, 1'b0, p, 11'd1, ERR_CHAR);
         end
      endcase
   endfunction

   // Queue the tokens one accepted transaction must produce; return 1 when the
   // character was actually lexed (not an end item, not swallowed by the lock).
   function automatic bit predict_character(input logic [7:0] c, input logic eoe);
      logic [10:0] p;
      bit          live;
      p = char_pos;
      live = !eoe && lx_state != LX_LOCKED;
      step_out.delete();
      if (eoe) begin
         if (lx_state != LX_LOCKED) flush_pending();
         put_token(KIND_END, OP_ADD, 3'd0, 1'b0, p, 11'd0, ERR_NONE);
         clear_lexer();
      end else if (lx_state == LX_LOCKED) begin
         // swallowed until the end item
      end else if (p >= MAX_LEN) begin
         lx_state = LX_LOCKED;
         put_token(KIND_ERROR, OP_ADD, 3'd0, 1'b0, p, 11'd0, ERR_LONG);
      end else begin
         char_pos = p + 11'd1;
         case (lx_state)
            LX_NUMBER: begin
               if (classify(c) == CC_DIGIT) begin
                  tok_len_q++;
               end else if (c == CH_POINT) begin
                  if (point_seen) begin
                     lx_state = LX_LOCKED;
                     put_token(KIND_ERROR, OP_ADD, 3'd0, 1'b0, p, 11'd1, ERR_POINT);
                  end else begin
                     point_seen = 1'b1;
                     tok_len_q++;
                  end
               end else begin
                  flush_pending();
                  lex_idle(c, p);
               end
            end
            LX_IDENT, LX_IDENT_GAP: begin
               if (lx_state == LX_IDENT && classify(c) == CC_LETTER) begin
                  tok_len_q++;
               end else if (classify(c) == CC_BLANK) begin
                  lx_state = LX_IDENT_GAP;
               end else if (c == CH_LPAREN) begin
                  put_token(KIND_FUNCTION, OP_ADD, 3'd0, 1'b0, tok_start_q, tok_len_q,
                            ERR_NONE);
                  lx_state = LX_IDLE;
                  unary_ok = 1'b1;
                  put_token(KIND_LPAREN, OP_ADD, 3'd0, 1'b0, p, 11'd1, ERR_NONE);
               end else begin
                  flush_pending();
                  lex_idle(c, p);
               end
            end
            LX_SLASH: begin
               if (c == CH_SLASH) begin
                  lx_state = LX_IDLE;
                  put_operator(OP_IDIV, tok_start_q, 11'd2);
               end else begin
                  flush_pending();
                  lex_idle(c, p);
               end
            end
            default: lex_idle(c, p);
         endcase
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) pending_tokens.insert(pending_tokens.size(), step_out[i]);
      return live;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_item(input logic [7:0] c, input logic eoe);
      // idle a random number of cycles, about a third of all cycles
      if (req_idle_on) begin
         while ($urandom_range(0, 99) < 33) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_ch          <= c;
      req_end_of_expr <= eoe;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (predict_character(c, eoe)) live_chars++;
      sent_chars++;
   endtask

   // send the characters, then close the expression with an end item
   task automatic send_chars(input char_q_type chars);
      foreach (chars[i]) send_item(chars[i], 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1);
      expr_count++;
   endtask

   task automatic send_text(input string s);
      char_q_type chars;
      for (int i = 0; i < s.len(); i++) chars.insert(chars.size(), s[i]);
      send_chars(chars);
   endtask

   function automatic logic [7:0] random_digit();
      return 8'h30 + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] random_letter();
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] random_blank();
      int r;
      r = $urandom_range(8, 13);
      return (r == 8) ? 8'h20 : 8'(r);
   endfunction

   // Mostly well-formed pieces with random content; a small share of stray
   // points and arbitrary bytes drives the error and lock paths.
   function automatic char_q_type random_expr();
      char_q_type q;
      int      pick;
      repeat ($urandom_range(1, 14)) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            if ($urandom_range(0, 3) == 0) q.insert(q.size(), CH_MINUS);
            repeat ($urandom_range(1, 4)) q.insert(q.size(), random_digit());
            if ($urandom_range(0, 3) == 0) begin
               q.insert(q.size(), CH_POINT);
               repeat ($urandom_range(0, 3)) q.insert(q.size(), random_digit());
            end
            if ($urandom_range(0, 19) == 0) q.insert(q.size(), CH_POINT);
         end else if (pick < 40) begin
            repeat ($urandom_range(1, 3)) q.insert(q.size(), random_letter());
         end else if (pick < 48) begin
            repeat ($urandom_range(1, 3)) q.insert(q.size(), random_letter());
            repeat ($urandom_range(0, 2)) q.insert(q.size(), random_blank());
            q.insert(q.size(), CH_LPAREN);
         end else if (pick < 68) begin
            pick = $urandom_range(0, 7);
            if (pick == 7) begin
               q.insert(q.size(), CH_SLASH);
               q.insert(q.size(), CH_SLASH);
            end else begin
               q.insert(q.size(), OPERATOR_CHARS[pick]);
            end
         end else if (pick < 76) begin
            q.insert(q.size(), CH_LPAREN);
         end else if (pick < 84) begin
            q.insert(q.size(), CH_RPAREN);
         end else if (pick < 94) begin
            q.insert(q.size(), random_blank());
         end else if (pick < 97) begin
            q.insert(q.size(), CH_POINT);
         end else begin
            q.insert(q.size(), 8'($urandom_range(0, 255)));
         end
      end
      return q;
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_directed_tokens();
      // every operator, spaced function and variable, unary and lone minus
      send_text("f (-.5)//a b%2^3!*4/5+-x-y");
      // repeated point, then a locked character
      send_text("7.1.x");
      // pending variable flushed ahead of a point outside a number
      send_text("q.");
   endtask

   task automatic test_random_traffic();
      int target;
      target = sent_chars + 730;
      while (sent_chars < target) begin
         // a stretch in the middle runs both sides flat out
         req_idle_on = !(sent_chars > target - 480 && sent_chars < target - 240);
         rsp_idle_on = req_idle_on;
         send_chars(random_expr());
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_output_backpressure();
      req_idle_on = 1'b0;
      hold_left = 80;
      repeat (3) send_text("ab(1)-cd (2)*(3)//e^(-4)!");
      req_idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------- receiver

   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (rsp_idle_on) begin
            rsp_ready <= ($urandom_range(0, 99) >= 33);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- checker

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      mismatch_count++;
      $display("MISMATCH %s: got %0d, expected %0d (token %0d, %0t)",
               what, got, want, checked_tokens, $realtime);
   endtask

   always @(posedge clock) begin : check_tokens
      token_rec_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_tokens.size() == 0) begin
            report_mismatch("token with none pending, kind", 16'(rsp_token_kind), 16'hFFFF);
         end else begin
            want = pending_tokens.pop_front();
            kinds_seen[want.kind] = 1'b1;
            errs_seen[want.err]   = 1'b1;
            if (rsp_token_kind !== want.kind)
               report_mismatch("token_kind", 16'(rsp_token_kind), 16'(want.kind));
            if (rsp_op_code !== want.op)
               report_mismatch("op_code", 16'(rsp_op_code), 16'(want.op));
            if (rsp_precedence !== want.prec)
               report_mismatch("precedence", 16'(rsp_precedence), 16'(want.prec));
            if (rsp_right_assoc !== want.ra)
               report_mismatch("right_assoc", 16'(rsp_right_assoc), 16'(want.ra));
            if (rsp_start_pos !== want.start)
               report_mismatch("start_pos", 16'(rsp_start_pos), 16'(want.start));
            if (rsp_token_len !== want.len)
               report_mismatch("token_len", 16'(rsp_token_len), 16'(want.len));
            if (rsp_error_code !== want.err)
               report_mismatch("error_code", 16'(rsp_error_code), 16'(want.err));
            if (rsp_last_in_run !== want.last)
               report_mismatch("last_in_run", 16'(rsp_last_in_run), 16'(want.last));
            checked_tokens++;
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d tokens outstanding",
                  stuck_cycles, pending_tokens.size());
         $display("*** FAILED ***");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- main

   initial begin
      clear_lexer();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed_tokens();
      test_random_traffic();
      test_output_backpressure();

      req_valid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d transactions in %0d expressions (%0d characters lexed), %0d tokens",
               sent_chars, expr_count, live_chars, checked_tokens);
      $display("token kinds seen %b, error codes seen %b, %0d mismatches",
               kinds_seen, errs_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/etl_pkg.sv
src/etl_front.sv
src/etl_fifo.sv
src/etl_back.sv
src/expression_token_lexer.sv
src/etl_checker.sv
tb/tb_expression_token_lexer.sv
